>>> rtl/stip_pkg.sv
// Shared types, constants and character decode helpers for the string-to-integer parser.
package stip_pkg;

  localparam int unsigned VALUE_BITS     = 64;
  localparam int unsigned OFFSET_BITS    = 16;
  localparam int unsigned RADIX_BITS     = 6;
  localparam int unsigned CHAR_BITS      = 8;
  localparam int unsigned IN_TDATA_BITS  = ((CHAR_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_BITS = ((VALUE_BITS + OFFSET_BITS + 7) / 8) * 8;
  localparam int unsigned CFG_DATA_BITS  = RADIX_BITS;
  localparam int unsigned CFG_IDX_BITS   = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_RADIX       = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIGNED_MODE = 1'd1;

  // radix codes
  localparam logic [RADIX_BITS-1:0] RADIX_AUTO = 6'd0;
  localparam logic [RADIX_BITS-1:0] RADIX_OCT  = 6'd8;
  localparam logic [RADIX_BITS-1:0] RADIX_DEC  = 6'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_HEX  = 6'd16;

  // characters of interest
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_BITS-1:0] CH_X_LO  = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_X_UP  = 8'h58;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  typedef enum logic [2:0] {
    PH_DONE,
    PH_LEAD,
    PH_PRE,
    PH_ZERO,
    PH_DIGITS
  } phase_e;

  typedef struct packed {
    logic                 first;
    logic [CHAR_BITS-1:0] character;
  } item_t;

  typedef struct packed {
    logic                   emit;
    logic [VALUE_BITS-1:0]  value;
    logic [OFFSET_BITS-1:0] end_offset;
  } result_t;

  typedef struct packed {
    logic                  ok;
    logic [RADIX_BITS-1:0] val;
  } digit_t;

  // space, tab, newline, vertical tab, form feed, return
  function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
    logic r;
    r = (c == 8'h20) || (c inside {[8'h09:8'h0d]});
    return r;
  endfunction

  function automatic digit_t digit_of(input logic [CHAR_BITS-1:0] c);
    digit_t d;
    d.ok  = 1'b1;
    d.val = '0;
    if (c inside {[8'h30:8'h39]}) begin
      d.val = RADIX_BITS'(c - 8'h30);
    end else if (c inside {[8'h61:8'h7a]}) begin
      d.val = RADIX_BITS'(c - 8'h57);
    end else if (c inside {[8'h41:8'h5a]}) begin
      d.val = RADIX_BITS'(c - 8'h37);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

>>> rtl/string_to_integer_parser.sv
// Streaming strtol/strtoul-style parser: one character item per cycle in, one result per string out.
// Characters enter one per cycle on the slave stream, tuser bit 0 marking the first character
// of a string. Sustained rate is one item per clock whenever the result side is ready; each
// item passes an input register and then the parse stage, whose single 64x6 multiply-add
// sets the cycle time. A result (value, end offset) is registered in the output register when its
// terminating character fires the parse stage. While a result waits in the output register the
// parse stage holds, so the slave side takes at most one further item until the result is
// taken. The radix register is sampled when a first item reaches the parse stage;
// characters arriving after a string's result and before the next first item give no result.
module string_to_integer_parser (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration write port
  input  logic                                    cfg_we_i,
  input  logic [stip_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [stip_pkg::CFG_DATA_BITS-1:0]      cfg_data_i,
  // character input
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [stip_pkg::IN_TDATA_BITS-1:0]      s_axis_tdata,   // [7:0] character
  input  logic [0:0]                              s_axis_tuser,   // [0] first
  // result output
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [stip_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata    // [63:0] value, [79:64] end_offset
);

  logic [stip_pkg::RADIX_BITS-1:0] radix_q, radix_d;
  logic                            signed_q, signed_d;

  stip_pkg::item_t   in_item, core_item;
  stip_pkg::result_t core_res;
  logic              core_valid, advance;

  logic                              out_valid_q, out_valid_d;
  logic [stip_pkg::VALUE_BITS-1:0]   out_value_q;
  logic [stip_pkg::OFFSET_BITS-1:0]  out_offset_q;

  always_comb begin
    radix_d  = radix_q;
    signed_d = signed_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        stip_pkg::CFG_RADIX:       radix_d  = cfg_data_i;
        stip_pkg::CFG_SIGNED_MODE: signed_d = cfg_data_i[0];
        default: begin
          radix_d  = radix_q;
          signed_d = signed_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= stip_pkg::RADIX_AUTO;
      signed_q <= 1'b1;
    end else begin
      radix_q  <= radix_d;
      signed_q <= signed_d;
    end
  end

  assign in_item.first     = s_axis_tuser[0];
  assign in_item.character = s_axis_tdata[stip_pkg::CHAR_BITS-1:0];

  // parse stage moves whenever the output register is free or being emptied
  assign advance = core_valid && (!out_valid_q || m_axis_tready);

  stip_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (core_valid),
    .item_o    (core_item)
  );

  stip_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (advance),
    .item_i        (core_item),
    .radix_i       (radix_q),
    .signed_mode_i (signed_q),
    .result_o      (core_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_valid_q || m_axis_tready) begin
      out_valid_d = core_res.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_res.emit) begin
      out_value_q  <= core_res.value;
      out_offset_q <= core_res.end_offset;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = stip_pkg::OUT_TDATA_BITS'({out_offset_q, out_value_q});

endmodule

>>> rtl/stip_in_reg.sv
// Input register stage: holds one character item until the parse stage takes it.
module stip_in_reg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  stip_pkg::item_t                     item_i,
  input  logic                                advance_i,
  output logic                                valid_o,
  output stip_pkg::item_t                     item_o
);

  logic            valid_q, valid_d;
  stip_pkg::item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/stip_core.sv
// Parse stage: phase machine, radix tracking, digit multiply-add and result forming.
module stip_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                fire_i,
  input  stip_pkg::item_t                     item_i,
  input  logic [stip_pkg::RADIX_BITS-1:0]     radix_i,
  input  logic                                signed_mode_i,
  output stip_pkg::result_t                   result_o
);

  stip_pkg::phase_e                     phase_q, phase_d, phase_nx;
  logic [stip_pkg::VALUE_BITS-1:0]      acc_q, acc_d;
  logic                                 neg_q, neg_d;
  logic [stip_pkg::RADIX_BITS-1:0]      radix_q, radix_d;
  logic [stip_pkg::OFFSET_BITS-1:0]     cnt_q, cnt_d;

  stip_pkg::phase_e                     ph;
  logic [stip_pkg::RADIX_BITS-1:0]      r_cur, r_dig;
  logic [stip_pkg::VALUE_BITS-1:0]      acc_base, acc_mac;
  logic                                 neg_base;
  logic [stip_pkg::OFFSET_BITS-1:0]     cnt_base;
  logic [stip_pkg::CHAR_BITS-1:0]       c;
  stip_pkg::digit_t                     dig;
  logic lead_ws, lead_minus, lead_plus, lead_take;
  logic at_pre, pre_zero, zero_x, at_dig, dig_take, emit, consume;

  // a first item restarts from the leading-space phase with cleared state
  assign c        = item_i.character;
  assign ph       = item_i.first ? stip_pkg::PH_LEAD : phase_q;
  assign r_cur    = item_i.first ? radix_i : radix_q;
  assign acc_base = item_i.first ? '0 : acc_q;
  assign neg_base = item_i.first ? 1'b0 : neg_q;
  assign cnt_base = item_i.first ? '0 : cnt_q;
  assign dig      = stip_pkg::digit_of(c);

  assign lead_ws    = (ph == stip_pkg::PH_LEAD) && stip_pkg::is_space(c);
  assign lead_minus = (ph == stip_pkg::PH_LEAD) && (c == stip_pkg::CH_MINUS) && signed_mode_i;
  assign lead_plus  = (ph == stip_pkg::PH_LEAD) && (c == stip_pkg::CH_PLUS);
  assign lead_take  = lead_ws || lead_minus || lead_plus;

  assign at_pre   = ((ph == stip_pkg::PH_LEAD) && !lead_take) || (ph == stip_pkg::PH_PRE);
  assign pre_zero = at_pre && (c == stip_pkg::CH_ZERO) &&
                    ((r_cur == stip_pkg::RADIX_AUTO) || (r_cur == stip_pkg::RADIX_HEX));
  assign zero_x   = (ph == stip_pkg::PH_ZERO) &&
                    ((c == stip_pkg::CH_X_LO) || (c == stip_pkg::CH_X_UP));
  assign at_dig   = (at_pre && !pre_zero) || ((ph == stip_pkg::PH_ZERO) && !zero_x) ||
                    (ph == stip_pkg::PH_DIGITS);
  assign r_dig    = (at_pre && (r_cur == stip_pkg::RADIX_AUTO)) ? stip_pkg::RADIX_DEC : r_cur;
  assign dig_take = at_dig && dig.ok && (dig.val < r_dig);
  assign emit     = at_dig && !dig_take;
  assign consume  = lead_take || pre_zero || zero_x || dig_take;

  assign acc_mac  = stip_pkg::VALUE_BITS'(acc_base * stip_pkg::VALUE_BITS'(r_dig)) +
                    stip_pkg::VALUE_BITS'(dig.val);

  // next phase
  always_comb begin
    phase_nx = ph;
    case (ph)
      stip_pkg::PH_LEAD: begin
        if (lead_ws) begin
          phase_nx = stip_pkg::PH_LEAD;
        end else if (lead_minus || lead_plus) begin
          phase_nx = stip_pkg::PH_PRE;
        end else if (pre_zero) begin
          phase_nx = stip_pkg::PH_ZERO;
        end else begin
          phase_nx = emit ? stip_pkg::PH_DONE : stip_pkg::PH_DIGITS;
        end
      end
      stip_pkg::PH_PRE: begin
        if (pre_zero) begin
          phase_nx = stip_pkg::PH_ZERO;
        end else begin
          phase_nx = emit ? stip_pkg::PH_DONE : stip_pkg::PH_DIGITS;
        end
      end
      stip_pkg::PH_ZERO: begin
        if (zero_x) begin
          phase_nx = stip_pkg::PH_DIGITS;
        end else begin
          phase_nx = emit ? stip_pkg::PH_DONE : stip_pkg::PH_DIGITS;
        end
      end
      stip_pkg::PH_DIGITS: begin
        phase_nx = emit ? stip_pkg::PH_DONE : stip_pkg::PH_DIGITS;
      end
      stip_pkg::PH_DONE: begin
        phase_nx = stip_pkg::PH_DONE;
      end
      default: begin
        phase_nx = stip_pkg::PH_DONE;
      end
    endcase
    phase_d = fire_i ? phase_nx : phase_q;
  end

  // datapath state and result
  always_comb begin
    acc_d   = acc_q;
    neg_d   = neg_q;
    radix_d = radix_q;
    cnt_d   = cnt_q;
    if (fire_i) begin
      acc_d   = dig_take ? acc_mac : acc_base;
      neg_d   = neg_base || lead_minus;
      if (pre_zero) begin
        radix_d = (r_cur == stip_pkg::RADIX_AUTO) ? stip_pkg::RADIX_OCT : r_cur;
      end else if (zero_x) begin
        radix_d = stip_pkg::RADIX_HEX;
      end else if (at_dig) begin
        radix_d = r_dig;
      end else begin
        radix_d = r_cur;
      end
      cnt_d = (consume && (cnt_base != stip_pkg::OFFSET_MAX)) ?
              cnt_base + stip_pkg::OFFSET_BITS'(1) : cnt_base;
    end
    result_o.emit       = fire_i && emit;
    result_o.value      = neg_base ? ('0 - acc_base) : acc_base;
    result_o.end_offset = cnt_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= stip_pkg::PH_DONE;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      radix_q <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      radix_q <= radix_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
